[hw/rtl/fmprc_pkg.sv]
// ----------------------------------------------------------------------------
// fmprc_pkg: shared types and constants
// request codes, protocol classes, sequencer states and the packet and rule records
// ----------------------------------------------------------------------------
package fmprc_pkg;

	typedef enum logic [1:0] {
		REQ_RECV  = 2'd0,
		REQ_SENT  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// word numbers inside one rule
	localparam logic [3:0] WORD_CTL   = 4'd0;
	localparam logic [3:0] WORD_MAC0  = 4'd1;
	localparam logic [3:0] WORD_IP0   = 4'd5;
	localparam logic [3:0] WORD_PORTS = 4'd13;

	// ethertypes as network values
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_ARP  = 16'h0806;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ESP  = 8'd50;
	localparam logic [7:0] PROTO_AH   = 8'd51;

	// protocol class codes
	localparam int unsigned NUM_CLASS = 9;
	localparam logic [4:0] PC_ANY   = 5'd0;
	localparam logic [4:0] PC_IPV4  = 5'd1;
	localparam logic [4:0] PC_IPV6  = 5'd2;
	localparam logic [4:0] PC_ICMP  = 5'd3;
	localparam logic [4:0] PC_IPSEC = 5'd4;
	localparam logic [4:0] PC_TCP   = 5'd5;
	localparam logic [4:0] PC_UDP   = 5'd6;
	localparam logic [4:0] PC_L2TP  = 5'd7;
	localparam logic [4:0] PC_ARP   = 5'd8;

	localparam logic [1:0] VER_V4 = 2'd1;
	localparam logic [1:0] VER_V6 = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [47:0] src_mac;
		logic [47:0] dst_mac;
		logic [15:0] eth_type;
		logic [7:0]  ip_proto;
		logic [63:0] src_ip_high;
		logic [63:0] src_ip_low;
		logic [63:0] dst_ip_high;
		logic [63:0] dst_ip_low;
		logic [31:0] port_pair;
	} pkt_t;

	// ip words: 0 src hi, 1 src lo, 2 src mask hi, 3 src mask lo, 4..7 same for dst
	typedef struct packed {
		logic [12:0]      ctl;
		logic [3:0][47:0] mac;
		logic [7:0][63:0] ip;
		logic [63:0]      ports;
	} rule_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_HIT  = 5'b00100,
		ST_RDW  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

[hw/rtl/fmprc_ram.sv]
// ----------------------------------------------------------------------------
// fmprc_ram: generic memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fmprc_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/fmprc_match.sv]
// ----------------------------------------------------------------------------
// fmprc_match: rule compare unit
// decides whether one rule record matches the held packet
// ----------------------------------------------------------------------------
module fmprc_match (
	input  fmprc_pkg::pkt_t  pkt,
	input  fmprc_pkg::rule_t rule,
	output logic             match
);

	logic [fmprc_pkg::NUM_CLASS-1:0] pcb;
	logic [fmprc_pkg::NUM_CLASS-1:0] verb;
	logic [4:0]  pc;
	logic [1:0]  dir;
	logic [1:0]  ver;
	logic        v6;
	logic        src_ok;
	logic        dst_ok;
	logic        ports_ok;
	logic [15:0] sp, dp;

	function automatic logic [fmprc_pkg::NUM_CLASS-1:0] cb(input logic [4:0] c);
		logic [fmprc_pkg::NUM_CLASS-1:0] b;
		b = '0;
		b[c[3:0]] = 1'b1;
		return b;
	endfunction

	always_comb begin
		pc  = rule.ctl[8:4];
		dir = rule.ctl[3:2];
		pcb = (pc < 5'(fmprc_pkg::NUM_CLASS)) ? cb(pc) : '0;
		v6  = (pkt.eth_type == fmprc_pkg::ETH_IPV6);
		ver = v6 ? fmprc_pkg::VER_V6 : fmprc_pkg::VER_V4;
		verb = v6 ? cb(fmprc_pkg::PC_IPV6) : cb(fmprc_pkg::PC_IPV4);

		if (v6) begin
			src_ok = ((rule.ip[2] & pkt.src_ip_high) == rule.ip[0]) &&
				((rule.ip[3] & pkt.src_ip_low) == rule.ip[1]);
			dst_ok = ((rule.ip[6] & pkt.dst_ip_high) == rule.ip[4]) &&
				((rule.ip[7] & pkt.dst_ip_low) == rule.ip[5]);
		end else begin
			src_ok = ((rule.ip[3][31:0] & pkt.src_ip_low[31:0]) == rule.ip[1][31:0]);
			dst_ok = ((rule.ip[7][31:0] & pkt.dst_ip_low[31:0]) == rule.ip[5][31:0]);
		end

		sp = pkt.port_pair[31:16];
		dp = pkt.port_pair[15:0];
		ports_ok = (sp >= rule.ports[63:48]) && (sp <= rule.ports[47:32]) &&
			(dp >= rule.ports[31:16]) && (dp <= rule.ports[15:0]);

		match = 1'b1;
		if (pkt.req_type == fmprc_pkg::REQ_RECV && !dir[0]) begin
			match = 1'b0;
		end else if (pkt.req_type == fmprc_pkg::REQ_SENT && !dir[1]) begin
			match = 1'b0;
		end else if ((rule.mac[1] & pkt.src_mac) != rule.mac[0]) begin
			match = 1'b0;
		end else if ((rule.mac[3] & pkt.dst_mac) != rule.mac[2]) begin
			match = 1'b0;
		end else if (pkt.eth_type == fmprc_pkg::ETH_ARP) begin
			match = |(pcb & (cb(fmprc_pkg::PC_ANY) | cb(fmprc_pkg::PC_ARP)));
		end else if (pkt.eth_type != fmprc_pkg::ETH_IPV4 && !v6) begin
			match = 1'b1;
		end else if (!(|(pcb & (cb(fmprc_pkg::PC_ANY) | verb | cb(fmprc_pkg::PC_ICMP) |
				cb(fmprc_pkg::PC_IPSEC) | cb(fmprc_pkg::PC_TCP) | cb(fmprc_pkg::PC_UDP) |
				cb(fmprc_pkg::PC_L2TP))))) begin
			match = 1'b0;
		end else if (rule.ctl[10:9] == ver && !src_ok) begin
			match = 1'b0;
		end else if (rule.ctl[12:11] == ver && !dst_ok) begin
			match = 1'b0;
		end else begin
			case (pkt.ip_proto) inside
				fmprc_pkg::PROTO_ICMP:
					match = |(pcb & (cb(fmprc_pkg::PC_ANY) | verb | cb(fmprc_pkg::PC_ICMP)));
				fmprc_pkg::PROTO_TCP:
					match = ports_ok &&
						|(pcb & (cb(fmprc_pkg::PC_ANY) | verb | cb(fmprc_pkg::PC_TCP)));
				fmprc_pkg::PROTO_UDP:
					match = ports_ok && |(pcb & (cb(fmprc_pkg::PC_ANY) | verb |
						cb(fmprc_pkg::PC_UDP) | cb(fmprc_pkg::PC_L2TP)));
				fmprc_pkg::PROTO_ESP, fmprc_pkg::PROTO_AH:
					match = |(pcb & (cb(fmprc_pkg::PC_ANY) | verb | cb(fmprc_pkg::PC_IPSEC)));
				default:
					match = 1'b1;
			endcase
		end
	end

endmodule

[hw/rtl/first_match_packet_rule_classifier.sv]
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier: first-match packet rule classifier
// checks a packet against the rule table in index order, counts hits
// ----------------------------------------------------------------------------
// throughput: one item at a time; a classify walks the rule memories one rule
// per cycle through the shared compare unit and stops at the first live match
// reset: arst_n clears the sequencer and the per-rule valid bits of the
// control words and hit counters; rule words read back absent, counters zero
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier #(
	parameter int RULES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [47:0] src_mac,
	input  logic [47:0] dst_mac,
	input  logic [15:0] eth_type,
	input  logic [7:0]  ip_proto,
	input  logic [63:0] src_ip_high,
	input  logic [63:0] src_ip_low,
	input  logic [63:0] dst_ip_high,
	input  logic [63:0] dst_ip_low,
	input  logic [31:0] port_pair,
	input  logic [9:0]  table_addr,
	input  logic [63:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pass_packet,
	output logic        rule_hit,
	output logic [5:0]  hit_index,
	output logic [63:0] read_data
);

	localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CW = $clog2(RULES + 1);

	fmprc_pkg::state_t state_q;
	fmprc_pkg::pkt_t   pkt_q;
	fmprc_pkg::rule_t  rule_rd;

	logic [RULES-1:0] ctl_vld_q;   // control word written since reset
	logic [RULES-1:0] hit_vld_q;   // hit counter written since reset
	logic [CW-1:0]    cnt_q;       // next rule to fetch
	logic [IW-1:0]    idx_s1;      // rule whose record is on the ram outputs
	logic             vld_s1;
	logic             ctlv_s1;

	logic        pass_q;
	logic        hit_q;
	logic [5:0]  hidx_q;
	logic [63:0] rdata_q;
	logic        tbl_ok_q;

	logic          in_acc;
	logic [3:0]    word;
	logic [15:0]   tbl_ext;
	logic [IW-1:0] tbl_idx;
	logic          tbl_ok;
	logic          wr_en;
	logic [IW-1:0] scan_addr;
	logic          match;
	logic          rule_live;
	logic [15:0]   idx_ext;
	logic [63:0]   hit_rd;
	logic [IW-1:0] hit_raddr;
	logic          hit_we;
	logic [63:0]   hit_wdata;

	assign in_stall  = (state_q != fmprc_pkg::ST_IDLE);
	assign out_valid = (state_q == fmprc_pkg::ST_OUT);
	assign in_acc    = in_valid && !in_stall;

	// table address decode: rule index in 9:4, word number in 3:0
	assign word    = table_addr[3:0];
	assign tbl_ext = {10'd0, table_addr[9:4]};
	assign tbl_idx = tbl_ext[IW-1:0];
	assign tbl_ok  = ({5'd0, table_addr[9:4]} < 11'(RULES));
	assign wr_en   = in_acc && (req_type == fmprc_pkg::REQ_WRITE) && tbl_ok;

	assign scan_addr = cnt_q[IW-1:0];

	// rule memories, one per rule word, all read at the scan address
	fmprc_ram #(.W(13), .D(RULES), .AW(IW)) u_ctl_ram (
		.clk   (clk),
		.we    (wr_en && word == fmprc_pkg::WORD_CTL),
		.waddr (tbl_idx),
		.wdata (write_data[12:0]),
		.raddr (scan_addr),
		.rdata (rule_rd.ctl)
	);

	for (genvar g = 0; g < 4; g++) begin : g_mac
		fmprc_ram #(.W(48), .D(RULES), .AW(IW)) u_mac_ram (
			.clk   (clk),
			.we    (wr_en && word == fmprc_pkg::WORD_MAC0 + 4'(g)),
			.waddr (tbl_idx),
			.wdata (write_data[47:0]),
			.raddr (scan_addr),
			.rdata (rule_rd.mac[g])
		);
	end

	for (genvar g = 0; g < 8; g++) begin : g_ip
		fmprc_ram #(.W(64), .D(RULES), .AW(IW)) u_ip_ram (
			.clk   (clk),
			.we    (wr_en && word == fmprc_pkg::WORD_IP0 + 4'(g)),
			.waddr (tbl_idx),
			.wdata (write_data),
			.raddr (scan_addr),
			.rdata (rule_rd.ip[g])
		);
	end

	fmprc_ram #(.W(64), .D(RULES), .AW(IW)) u_port_ram (
		.clk   (clk),
		.we    (wr_en && word == fmprc_pkg::WORD_PORTS),
		.waddr (tbl_idx),
		.wdata (write_data),
		.raddr (scan_addr),
		.rdata (rule_rd.ports)
	);

	// shared compare unit, fed one rule record per cycle
	fmprc_match u_match (
		.pkt   (pkt_q),
		.rule  (rule_rd),
		.match (match)
	);

	// rule takes part only when written, present and enabled
	assign rule_live = vld_s1 && ctlv_s1 && rule_rd.ctl[1] && rule_rd.ctl[0];
	assign idx_ext   = 16'(idx_s1);

	// hit counters: read for a counter read or on a match, written back +1
	assign hit_raddr = (state_q == fmprc_pkg::ST_IDLE) ? tbl_idx : idx_s1;
	assign hit_we    = (state_q == fmprc_pkg::ST_HIT);
	assign hit_wdata = (hit_vld_q[idx_s1] ? hit_rd : 64'd0) + 64'd1;

	fmprc_ram #(.W(64), .D(RULES), .AW(IW)) u_hit_ram (
		.clk   (clk),
		.we    (hit_we),
		.waddr (idx_s1),
		.wdata (hit_wdata),
		.raddr (hit_raddr),
		.rdata (hit_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fmprc_pkg::ST_IDLE;
			ctl_vld_q <= '0;
			hit_vld_q <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				fmprc_pkg::ST_IDLE: begin
					if (in_acc) begin
						cnt_q  <= '0;
						vld_s1 <= 1'b0;
						if (req_type == fmprc_pkg::REQ_WRITE) begin
							if (tbl_ok && word == fmprc_pkg::WORD_CTL) begin
								ctl_vld_q[tbl_idx] <= 1'b1;
							end
							state_q <= fmprc_pkg::ST_OUT;
						end else if (req_type == fmprc_pkg::REQ_READ) begin
							state_q <= fmprc_pkg::ST_RDW;
						end else begin
							state_q <= fmprc_pkg::ST_SCAN;
						end
					end
				end
				fmprc_pkg::ST_SCAN: begin
					if (rule_live && match) begin
						state_q <= fmprc_pkg::ST_HIT;
					end else if (vld_s1 && idx_s1 == IW'(RULES - 1)) begin
						state_q <= fmprc_pkg::ST_OUT;
					end else begin
						vld_s1 <= (cnt_q < CW'(RULES));
						if (cnt_q < CW'(RULES)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				fmprc_pkg::ST_HIT: begin
					hit_vld_q[idx_s1] <= 1'b1;
					state_q <= fmprc_pkg::ST_OUT;
				end
				fmprc_pkg::ST_RDW: begin
					state_q <= fmprc_pkg::ST_OUT;
				end
				fmprc_pkg::ST_OUT: begin
					if (!out_stall) begin
						state_q <= fmprc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fmprc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (state_q == fmprc_pkg::ST_IDLE && in_acc) begin
			pkt_q.req_type    <= req_type;
			pkt_q.src_mac     <= src_mac;
			pkt_q.dst_mac     <= dst_mac;
			pkt_q.eth_type    <= eth_type;
			pkt_q.ip_proto    <= ip_proto;
			pkt_q.src_ip_high <= src_ip_high;
			pkt_q.src_ip_low  <= src_ip_low;
			pkt_q.dst_ip_high <= dst_ip_high;
			pkt_q.dst_ip_low  <= dst_ip_low;
			pkt_q.port_pair   <= port_pair;
			idx_s1  <= tbl_idx;          // held as the counter index for a read
			ctlv_s1 <= 1'b0;
			pass_q  <= (req_type == fmprc_pkg::REQ_RECV) || (req_type == fmprc_pkg::REQ_SENT);
			hit_q   <= 1'b0;
			hidx_q  <= 6'd0;
			rdata_q <= 64'd0;
		end else if (state_q == fmprc_pkg::ST_SCAN) begin
			if (rule_live && match) begin
				pass_q <= 1'b0;
				hit_q  <= 1'b1;
				hidx_q <= idx_ext[5:0];
			end else begin
				idx_s1  <= scan_addr;
				ctlv_s1 <= ctl_vld_q[scan_addr];
			end
		end else if (state_q == fmprc_pkg::ST_RDW) begin
			rdata_q <= (tbl_ok_q && hit_vld_q[idx_s1]) ? hit_rd : 64'd0;
		end
	end

	// range flag of a counter read, kept for the wait cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tbl_ok_q <= tbl_ok;
		end
	end

	assign pass_packet = pass_q;
	assign rule_hit    = hit_q;
	assign hit_index   = hidx_q;
	assign read_data   = rdata_q;

	// a hit always drops the packet
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rule_hit |-> !pass_packet)
		else $error("hit item not dropped");

	// counter data only on items that are neither classified hits nor passed packets
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 64'd0 |-> !rule_hit && !pass_packet)
		else $error("read data on a classify item");

	// a counter update always leads straight to the result
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fmprc_pkg::ST_HIT |=> state_q == fmprc_pkg::ST_OUT)
		else $error("hit update not followed by result");

	// the scan counter never goes beyond RULES, one past the last rule
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fmprc_pkg::ST_SCAN |-> cnt_q <= CW'(RULES))
		else $error("scan ran past the last rule");

endmodule
